FILE: design/rrb_pkg.sv
`default_nettype none
package rrb_pkg;

	localparam int NUM_TASKS_DEF = 4;
	localparam int QUANTUM = 2;
	localparam int NUM_BURST = 4;

	localparam logic [3:0] RESET_BURST = 4'd4;
	localparam logic [15:0] RESET_BASE_PC = 16'd1000;

	typedef enum logic [1:0] {
		EV_RAN = 2'd0,
		EV_DONE = 2'd1,
		EV_BLOCKED = 2'd2,
		EV_IDLE = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		REG_BURST0 = 3'd0,
		REG_BURST1 = 3'd1,
		REG_BURST2 = 3'd2,
		REG_BURST3 = 3'd3,
		REG_BASE_PC = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [NUM_BURST-1:0][3:0] burst;
		logic [15:0] base_pc;
	} cfg_t;

	typedef struct packed {
		logic [1:0] task_id;
		event_t event_res;
		logic [15:0] pc_after;
		logic [3:0] executed_after;
		logic all_done;
	} result_t;

endpackage
`default_nettype wire

FILE: design/rrb_qmem.sv
`default_nettype none
module rrb_qmem #(
	parameter int NUM_TASKS = rrb_pkg::NUM_TASKS_DEF,
	parameter int TW = $clog2(rrb_pkg::NUM_TASKS_DEF)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic re,
	input wire logic [TW-1:0] ridx_r,
	input wire logic [TW-1:0] ridx_b,
	output logic [TW-1:0] rdata_r,
	output logic [TW-1:0] rdata_b,
	input wire logic we,
	input wire logic wblk,
	input wire logic [TW-1:0] widx,
	input wire logic [TW-1:0] wdata
);

	localparam int DEPTH = 2 ** (TW + 1);

	// lower half: ready queue, upper half: blocked queue
	logic [TW-1:0] mem [DEPTH];
	logic [NUM_TASKS-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[{wblk, widx}] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_r <= vld_q[ridx_r] ? mem[{1'b0, ridx_r}] : ridx_r;
			rdata_b <= mem[{1'b1, ridx_b}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we && !wblk) begin
			vld_q[widx] <= 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: design/rrb_xmem.sv
`default_nettype none
module rrb_xmem #(
	parameter int NUM_TASKS = rrb_pkg::NUM_TASKS_DEF,
	parameter int TW = $clog2(rrb_pkg::NUM_TASKS_DEF)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic re,
	input wire logic [TW-1:0] raddr,
	output logic [3:0] rdata,
	input wire logic we,
	input wire logic [TW-1:0] waddr,
	input wire logic [3:0] wdata
);

	logic [3:0] mem [NUM_TASKS];
	logic [NUM_TASKS-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= vld_q[raddr] ? mem[raddr] : 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: design/rrb_sched.sv
`default_nettype none
module rrb_sched #(
	parameter int NUM_TASKS = rrb_pkg::NUM_TASKS_DEF,
	parameter int TW = $clog2(rrb_pkg::NUM_TASKS_DEF)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire rrb_pkg::cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [3:0] in_mask,
	output logic out_valid,
	input wire logic out_ready,
	output rrb_pkg::result_t out_res
);

	localparam int CW = $clog2(NUM_TASKS + 1);
	localparam logic [TW-1:0] LAST = TW'(NUM_TASKS - 1);
	localparam logic [TW:0] WRAP = (TW+1)'(NUM_TASKS);
	localparam logic [CW-1:0] FULL = CW'(NUM_TASKS);

	typedef enum logic [1:0] {ST_IDLE, ST_S1, ST_S2} state_t;

	state_t state_q;
	logic [3:0] mask_q;
	logic [TW-1:0] rhead_q, bhead_q;
	logic [CW-1:0] rcnt_q, bcnt_q;
	logic [TW-1:0] task_s2;
	logic has_s2, busy_s2;
	logic out_valid_q;
	rrb_pkg::result_t res_q;

	logic acc;
	logic [TW-1:0] rd_r, rd_b;
	logic [3:0] x_rd;

	logic b_do, b_busy, b_free, r_push, has1;
	logic [CW-1:0] rc1, rcnt_n1, bcnt_n1;
	logic [TW-1:0] rhead_n1, bhead_n1, task_sel;
	logic q_we, q_wblk;
	logic [TW-1:0] q_widx, q_wdata;

	logic fire;
	logic [4:0] e_sum;
	logic [3:0] e_sat, exe_out, bur;
	logic x_we;
	rrb_pkg::event_t ev;
	logic [CW-1:0] rcnt_n2, bcnt_n2;
	logic [15:0] pc;
	rrb_pkg::result_t res_d;

	function automatic logic [TW-1:0] inc(input logic [TW-1:0] t);
		return (t == LAST) ? '0 : t + 1'b1;
	endfunction

	function automatic logic [TW-1:0] wrap(input logic [TW-1:0] h, input logic [CW-1:0] c);
		logic [TW:0] s;
		s = {1'b0, h} + (TW+1)'(c);
		return (s >= WRAP) ? TW'(s - WRAP) : TW'(s);
	endfunction

	function automatic logic is_busy(input logic [3:0] m, input logic [TW-1:0] t);
		logic [31:0] t32;
		t32 = 32'(t);
		return (t32 < 32'(rrb_pkg::NUM_BURST)) && m[t32[1:0]];
	endfunction

	function automatic logic [3:0] burst_of(input rrb_pkg::cfg_t c, input logic [TW-1:0] t);
		logic [31:0] t32;
		t32 = 32'(t);
		return (t32 < 32'(rrb_pkg::NUM_BURST)) ? c.burst[t32[1:0]] : 4'd0;
	endfunction

	function automatic logic [15:0] pc_base(input rrb_pkg::cfg_t c, input logic [TW-1:0] t);
		logic [15:0] acc_pc;
		acc_pc = c.base_pc;
		for (int i = 0; i < rrb_pkg::NUM_BURST; i++) begin
			if (32'(i) < 32'(t)) begin
				acc_pc = acc_pc + 16'(c.burst[i]);
			end
		end
		return acc_pc;
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign acc = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_res = res_q;

	// S1: blocked head step, then ready head pop
	always_comb begin
		b_do = (bcnt_q != '0);
		b_busy = is_busy(mask_q, rd_b);
		b_free = b_do && !b_busy;
		bhead_n1 = b_do ? inc(bhead_q) : bhead_q;
		bcnt_n1 = b_free ? bcnt_q - 1'b1 : bcnt_q;
		r_push = b_free && (rcnt_q < FULL);
		rc1 = rcnt_q + CW'(r_push);
		has1 = (rc1 != '0);
		task_sel = (rcnt_q == '0) ? rd_b : rd_r;
		rhead_n1 = has1 ? inc(rhead_q) : rhead_q;
		rcnt_n1 = has1 ? rc1 - 1'b1 : rc1;
	end

	// S2: run, block or complete the popped task, or report idle when none was popped
	always_comb begin
		fire = (state_q == ST_S2) && (!out_valid_q || out_ready);
		bur = burst_of(cfg, task_s2);
		e_sum = 5'(x_rd) + 5'(rrb_pkg::QUANTUM);
		e_sat = (e_sum > 5'd15) ? 4'd15 : e_sum[3:0];
		x_we = 1'b0;
		rcnt_n2 = rcnt_q;
		bcnt_n2 = bcnt_q;
		exe_out = x_rd;
		ev = rrb_pkg::EV_IDLE;
		if (!has_s2) begin
			exe_out = 4'd0;
		end else if (busy_s2) begin
			ev = rrb_pkg::EV_BLOCKED;
			if (bcnt_q < FULL) begin
				bcnt_n2 = bcnt_q + 1'b1;
			end
		end else if (x_rd >= bur) begin
			ev = rrb_pkg::EV_DONE;
		end else begin
			x_we = fire;
			exe_out = e_sat;
			if (e_sat >= bur) begin
				ev = rrb_pkg::EV_DONE;
			end else begin
				ev = rrb_pkg::EV_RAN;
				if (rcnt_q < FULL) begin
					rcnt_n2 = rcnt_q + 1'b1;
				end
			end
		end
		pc = has_s2 ? pc_base(cfg, task_s2) + 16'(exe_out) : 16'd0;
		res_d.task_id = has_s2 ? 2'(task_s2) : 2'd0;
		res_d.event_res = ev;
		res_d.pc_after = pc;
		res_d.executed_after = exe_out;
		res_d.all_done = (rcnt_n2 == '0) && (bcnt_n2 == '0);
	end

	always_comb begin
		q_we = 1'b0;
		q_wblk = 1'b0;
		q_widx = wrap(rhead_q, rcnt_q);
		q_wdata = rd_b;
		if (state_q == ST_S1) begin
			q_we = b_do && (b_busy || r_push);
			q_wblk = b_busy;
			q_widx = b_busy ? wrap(bhead_q, bcnt_q) : wrap(rhead_q, rcnt_q);
		end else if (fire && has_s2) begin
			q_wdata = task_s2;
			if (busy_s2) begin
				q_we = (bcnt_q < FULL);
				q_wblk = 1'b1;
				q_widx = wrap(bhead_q, bcnt_q);
			end else begin
				q_we = (ev == rrb_pkg::EV_RAN) && (rcnt_q < FULL);
			end
		end
	end

	rrb_qmem #(.NUM_TASKS(NUM_TASKS), .TW(TW)) u_qmem (
		.clk(clk),
		.arst_n(arst_n),
		.re(acc),
		.ridx_r(rhead_q),
		.ridx_b(bhead_q),
		.rdata_r(rd_r),
		.rdata_b(rd_b),
		.we(q_we),
		.wblk(q_wblk),
		.widx(q_widx),
		.wdata(q_wdata)
	);

	rrb_xmem #(.NUM_TASKS(NUM_TASKS), .TW(TW)) u_xmem (
		.clk(clk),
		.arst_n(arst_n),
		.re((state_q == ST_S1) && has1),
		.raddr(task_sel),
		.rdata(x_rd),
		.we(x_we),
		.waddr(task_s2),
		.wdata(e_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rhead_q <= '0;
			bhead_q <= '0;
			rcnt_q <= FULL;
			bcnt_q <= '0;
			has_s2 <= 1'b0;
			busy_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_S1;
					end
				end
				ST_S1: begin
					rhead_q <= rhead_n1;
					bhead_q <= bhead_n1;
					rcnt_q <= rcnt_n1;
					bcnt_q <= bcnt_n1;
					has_s2 <= has1;
					busy_s2 <= is_busy(mask_q, task_sel);
					state_q <= ST_S2;
				end
				ST_S2: begin
					if (fire) begin
						rcnt_q <= rcnt_n2;
						bcnt_q <= bcnt_n2;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mask_q <= in_mask;
		end
		if (state_q == ST_S1) begin
			task_s2 <= task_sel;
		end
		if (fire) begin
			res_q <= res_d;
		end
	end

endmodule
`default_nettype wire

FILE: design/round_robin_with_blocking_core.sv
`default_nettype none
// Round-robin scheduler with a blocked queue. Each stream transaction on the slave
// side is one scheduling slot carrying the busy mask of held resources; each slot
// yields exactly one result transaction. The accepting edge reads both heads from the
// queue memory; state S1 then moves the blocked head and pops the ready head while
// it reads that task's executed count, and state S2 updates the count, requeues the
// task and registers the result, waiting while the sink has not taken the last one.
// The next slot is accepted once the result is registered, even while that result
// still waits for the sink.
// Both queues share one synchronous memory and the executed counts sit in a second
// one; per-entry valid bits supply the reset contents, so no clearing pass is
// needed. Program burst lengths and base program counter over APB only while idle.
module round_robin_with_blocking_core #(
	parameter int NUM_TASKS = rrb_pkg::NUM_TASKS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata,   // [3:0] busy_mask
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [23:0] m_axis_tdata,      // [1:0] task_id, [17:2] pc_after,
	                                       // [21:18] executed_after
	output logic [1:0] m_axis_tuser,       // [1:0] event_res
	output logic m_axis_tlast              // all_done
);

	localparam int TW = $clog2(NUM_TASKS);

	rrb_pkg::cfg_t cfg_q;
	rrb_pkg::result_t res;
	rrb_pkg::reg_idx_t ridx;
	logic wr_en;

	assign pready = 1'b1;
	assign ridx = rrb_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite && pready;

	always_comb begin
		case (ridx)
			rrb_pkg::REG_BURST0: prdata = 32'(cfg_q.burst[0]);
			rrb_pkg::REG_BURST1: prdata = 32'(cfg_q.burst[1]);
			rrb_pkg::REG_BURST2: prdata = 32'(cfg_q.burst[2]);
			rrb_pkg::REG_BURST3: prdata = 32'(cfg_q.burst[3]);
			rrb_pkg::REG_BASE_PC: prdata = 32'(cfg_q.base_pc);
			default: prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst <= {rrb_pkg::NUM_BURST{rrb_pkg::RESET_BURST}};
			cfg_q.base_pc <= rrb_pkg::RESET_BASE_PC;
		end else if (wr_en) begin
			case (ridx)
				rrb_pkg::REG_BURST0: cfg_q.burst[0] <= pwdata[3:0];
				rrb_pkg::REG_BURST1: cfg_q.burst[1] <= pwdata[3:0];
				rrb_pkg::REG_BURST2: cfg_q.burst[2] <= pwdata[3:0];
				rrb_pkg::REG_BURST3: cfg_q.burst[3] <= pwdata[3:0];
				rrb_pkg::REG_BASE_PC: cfg_q.base_pc <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	rrb_sched #(.NUM_TASKS(NUM_TASKS), .TW(TW)) u_sched (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_mask(s_axis_tdata[3:0]),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res(res)
	);

	assign m_axis_tdata = {2'b00, res.executed_after, res.pc_after, res.task_id};
	assign m_axis_tuser = res.event_res;
	assign m_axis_tlast = res.all_done;

`ifndef SYNTHESIS
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == rrb_pkg::EV_IDLE) |-> m_axis_tdata == 24'd0)
		else $error("idle slot carries nonzero payload");

	a_ran_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == rrb_pkg::EV_RAN || m_axis_tuser == rrb_pkg::EV_BLOCKED)
		|-> !m_axis_tlast)
		else $error("requeued task reported with both queues empty");

	a_one_slot: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("slot accepted while previous slot in progress");
`endif

endmodule
`default_nettype wire

FILE: dv/round_robin_with_blocking_core_tb.sv
`timescale 1ns / 100ps
module round_robin_with_blocking_core_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD_CYCLES = 60;

	typedef struct packed {
		logic [3:0][1:0] slot;
		logic [1:0] head;
		logic [2:0] cnt;
	} task_fifo_t;

	typedef struct packed {
		logic is_cfg;
		logic typed;
		rrb_pkg::reg_idx_t idx;
		logic [15:0] value;
		rrb_pkg::result_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;    // [3:0] busy_mask
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [1:0] task_id, [17:2] pc_after, [21:18] executed_after
	logic [1:0] m_axis_tuser;         // [1:0] event_res
	logic m_axis_tlast;               // all_done

	task_fifo_t ready_q;
	task_fifo_t blocked_q;
	logic [3:0] exec_cnt [4];
	logic [3:0] burst_cfg [4];
	logic [15:0] base_pc_cfg;

	rrb_pkg::result_t slot_outcomes [$];
	rrb_pkg::result_t outcome_head;
	plan_row_t plan [$];

	logic calm = 1'b0;
	logic long_hold_req = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;
	int mismatches = 0;
	int slots_sent = 0;
	int results_seen = 0;
	int cfg_writes = 0;
	int seen_events [4] = '{0, 0, 0, 0};

	round_robin_with_blocking_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #1 clk = ~clk;

	function automatic task_fifo_t fifo_pushed(task_fifo_t q, logic [1:0] tid);
		logic [1:0] pos;
		if (q.cnt < 3'd4) begin
			pos = q.head + q.cnt[1:0];
			q.slot[pos] = tid;
			q.cnt = q.cnt + 3'd1;
		end
		return q;
	endfunction

	function automatic task_fifo_t fifo_popped(task_fifo_t q);
		q.head = q.head + 2'd1;
		q.cnt = q.cnt - 3'd1;
		return q;
	endfunction

	function automatic rrb_pkg::result_t schedule_slot(logic [3:0] mask);
		rrb_pkg::result_t r;
		logic [1:0] tid;
		logic [4:0] sum;
		logic [15:0] pc;
		int i;
		r = '0;
		r.event_res = rrb_pkg::EV_IDLE;
		if (blocked_q.cnt != 3'd0) begin
			tid = blocked_q.slot[blocked_q.head];
			blocked_q = fifo_popped(blocked_q);
			if (!mask[tid])
				ready_q = fifo_pushed(ready_q, tid);
			else
				blocked_q = fifo_pushed(blocked_q, tid);
		end
		if (ready_q.cnt != 3'd0) begin
			tid = ready_q.slot[ready_q.head];
			ready_q = fifo_popped(ready_q);
			if (mask[tid]) begin
				blocked_q = fifo_pushed(blocked_q, tid);
				r.event_res = rrb_pkg::EV_BLOCKED;
			end else if (exec_cnt[tid] >= burst_cfg[tid]) begin
				r.event_res = rrb_pkg::EV_DONE;
			end else begin
				sum = {1'b0, exec_cnt[tid]} + 5'(rrb_pkg::QUANTUM);
				if (sum > 5'd15)
					sum = 5'd15;
				exec_cnt[tid] = sum[3:0];
				if (sum[3:0] >= burst_cfg[tid]) begin
					r.event_res = rrb_pkg::EV_DONE;
				end else begin
					r.event_res = rrb_pkg::EV_RAN;
					ready_q = fifo_pushed(ready_q, tid);
				end
			end
			pc = base_pc_cfg;
			for (i = 0; i < int'(tid); i++)
				pc = pc + 16'(burst_cfg[i]);
			pc = pc + 16'(exec_cnt[tid]);
			r.task_id = tid;
			r.executed_after = exec_cnt[tid];
			r.pc_after = pc;
		end
		r.all_done = (ready_q.cnt == 3'd0) && (blocked_q.cnt == 3'd0);
		return r;
	endfunction

	function automatic plan_row_t slot_row(logic [3:0] mask);
		plan_row_t row;
		row = '0;
		row.value = {12'b0, mask};
		return row;
	endfunction

	function automatic plan_row_t known_row(logic [3:0] mask, logic [1:0] tid,
			rrb_pkg::event_t ev, logic [15:0] pc, logic [3:0] exe, logic done);
		plan_row_t row;
		row = slot_row(mask);
		row.typed = 1'b1;
		row.want.task_id = tid;
		row.want.event_res = ev;
		row.want.pc_after = pc;
		row.want.executed_after = exe;
		row.want.all_done = done;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(rrb_pkg::reg_idx_t idx, logic [15:0] value);
		plan_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.value = value;
		return row;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (slot_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic offer_slot(input logic [3:0] mask, input logic typed,
			input rrb_pkg::result_t typed_want);
		rrb_pkg::result_t predicted;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, mask};
		do
			@(posedge clk);
		while (s_axis_tready !== 1'b1);
		predicted = schedule_slot(mask);
		slot_outcomes.push_back(typed ? typed_want : predicted);
		slots_sent++;
	endtask

	task automatic write_reg(input rrb_pkg::reg_idx_t idx, input logic [15:0] value);
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == rrb_pkg::REG_BASE_PC)
			base_pc_cfg = value;
		else
			burst_cfg[int'(idx)] = value[3:0];
		cfg_writes++;
	endtask

	task automatic random_slots(input int count, input int busy_pct, input int hold_at,
			input int pause_at);
		logic [3:0] mask;
		int n;
		int b;
		for (n = 0; n < count; n++) begin
			if (n == hold_at)
				long_hold_req = 1'b1;
			if (n == pause_at)
				drain_results();
			for (b = 0; b < 4; b++)
				mask[b] = ($urandom_range(0, 99) < busy_pct);
			offer_slot(mask, 1'b0, '0);
		end
	endtask

	// sink side: random short stalls, one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD_CYCLES;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 4);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			results_seen++;
			seen_events[m_axis_tuser]++;
			if (slot_outcomes.size() == 0) begin
				$error("result transaction with no slot outstanding");
				mismatches++;
			end else begin
				outcome_head = slot_outcomes.pop_front();
				check_field("task_id", 16'(outcome_head.task_id), 16'(m_axis_tdata[1:0]));
				check_field("event_res", 16'(outcome_head.event_res), 16'(m_axis_tuser));
				check_field("pc_after", outcome_head.pc_after, m_axis_tdata[17:2]);
				check_field("executed_after", 16'(outcome_head.executed_after),
					16'(m_axis_tdata[21:18]));
				check_field("all_done", 16'(outcome_head.all_done), 16'(m_axis_tlast));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		ready_q.slot = {2'd3, 2'd2, 2'd1, 2'd0};
		ready_q.head = 2'd0;
		ready_q.cnt = 3'd4;
		blocked_q = '0;
		for (int i = 0; i < 4; i++) begin
			exec_cnt[i] = 4'd0;
			burst_cfg[i] = rrb_pkg::RESET_BURST;
		end
		base_pc_cfg = rrb_pkg::RESET_BASE_PC;

		// run, block, rotate, unblock from reset settings
		plan.push_back(known_row(4'h0, 2'd0, rrb_pkg::EV_RAN, 16'd1002, 4'd2, 1'b0));
		plan.push_back(known_row(4'hF, 2'd1, rrb_pkg::EV_BLOCKED, 16'd1004, 4'd0, 1'b0));
		plan.push_back(known_row(4'hF, 2'd2, rrb_pkg::EV_BLOCKED, 16'd1008, 4'd0, 1'b0));
		plan.push_back(known_row(4'h0, 2'd3, rrb_pkg::EV_RAN, 16'd1014, 4'd2, 1'b0));
		// burst of 15 forces count saturation; base near top forces pc wrap
		plan.push_back(cfg_row(rrb_pkg::REG_BURST0, 16'd15));
		plan.push_back(cfg_row(rrb_pkg::REG_BURST1, 16'd14));
		plan.push_back(cfg_row(rrb_pkg::REG_BURST2, 16'd14));
		plan.push_back(cfg_row(rrb_pkg::REG_BURST3, 16'd14));
		plan.push_back(cfg_row(rrb_pkg::REG_BASE_PC, 16'd65530));
		plan.push_back(slot_row(4'hF));
		plan.push_back(slot_row(4'h0));
		plan.push_back(slot_row(4'hE));
		plan.push_back(slot_row(4'hD));
		plan.push_back(slot_row(4'hB));
		plan.push_back(slot_row(4'h7));
		plan.push_back(slot_row(4'h1));
		plan.push_back(slot_row(4'h2));
		plan.push_back(slot_row(4'h4));
		plan.push_back(slot_row(4'h8));
		plan.push_back(slot_row(4'h5));
		plan.push_back(slot_row(4'hA));
		plan.push_back(slot_row(4'h3));
		plan.push_back(slot_row(4'hC));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].idx, plan[i].value);
			else
				offer_slot(plan[i].value[3:0], plan[i].typed, plan[i].want);
		end

		// mostly held resources keep tasks cycling through the blocked queue
		write_reg(rrb_pkg::REG_BASE_PC, 16'd0);
		random_slots(350, 97, 40, -1);

		// lower bursts below counts already reached; zero burst
		write_reg(rrb_pkg::REG_BURST1, 16'd2);
		write_reg(rrb_pkg::REG_BURST2, 16'd0);
		write_reg(rrb_pkg::REG_BASE_PC, 16'd65535);
		random_slots(300, 90, -1, 120);

		write_reg(rrb_pkg::REG_BURST0, 16'd14);
		write_reg(rrb_pkg::REG_BURST3, 16'd2);
		write_reg(rrb_pkg::REG_BURST2, 16'd8);
		write_reg(rrb_pkg::REG_BASE_PC, 16'($urandom_range(0, 65535)));
		random_slots(250, 60, -1, -1);

		// run to completion and idle slots without stalls
		drain_results();
		calm = 1'b1;
		random_slots(150, 20, -1, -1);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("summary: %0d slots sent, %0d results checked, %0d register writes",
			slots_sent, results_seen, cfg_writes);
		$display("summary: ran %0d, completed %0d, blocked %0d, idle %0d",
			seen_events[rrb_pkg::EV_RAN], seen_events[rrb_pkg::EV_DONE],
			seen_events[rrb_pkg::EV_BLOCKED], seen_events[rrb_pkg::EV_IDLE]);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
